// ----- sv/pcit_pkg.sv -----
// ----------------------------------------------------------------------------
// pcit_pkg
// Shared widths, function and status codes, and sequencer states for the
// phase clock index tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package pcit_pkg;

  // Fixed field widths
  localparam int IDX_W  = 8;
  localparam int CFG_W  = 9;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Input item function codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_TAIL    = 2'd1,
    STAT_UNAVAIL = 2'd2,
    STAT_REGRESS = 2'd3
  } status_e;

  // Update sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ORIGIN,
    ST_ELAPSED,
    ST_ARTIFACT,
    ST_PROBE,
    ST_COMPARE,
    ST_TAIL_RD,
    ST_TAIL,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- sv/pcit_if.sv -----
// ----------------------------------------------------------------------------
// pcit_in_if / pcit_out_if
// Valid/ready channels of the phase clock index tracker: command items in,
// lookup results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface pcit_in_if #(
  parameter int TIME_BITS = 48
);
  import pcit_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     entry_index;
  logic [TIME_BITS-1:0] entry_time_ns;
  logic [TIME_BITS-1:0] runtime_ns;
  logic [IDX_W-1:0]     index_limit;

  modport source (
    output valid, func, entry_index, entry_time_ns, runtime_ns, index_limit,
    input  ready
  );
  modport sink (
    input  valid, func, entry_index, entry_time_ns, runtime_ns, index_limit,
    output ready
  );
endinterface

interface pcit_out_if #(
  parameter int TIME_BITS = 48
);
  import pcit_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [STAT_W-1:0]    status;
  logic                 result_valid;
  logic [IDX_W-1:0]     phase_index;
  logic [TIME_BITS-1:0] elapsed_ns;
  logic [TIME_BITS-1:0] artifact_time_ns;

  modport source (
    output valid, status, result_valid, phase_index, elapsed_ns, artifact_time_ns,
    input  ready
  );
  modport sink (
    input  valid, status, result_valid, phase_index, elapsed_ns, artifact_time_ns,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/pcit_ram.sv -----
// ----------------------------------------------------------------------------
// pcit_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pcit_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/phase_clock_index_tracker.sv -----
// ----------------------------------------------------------------------------
// phase_clock_index_tracker
// Maps runtime timestamps onto a table of ascending nominal sample times.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_i (valid/ready). A write item (func 0) stores
// a table entry, a clear item (func 2) drops the latched clock origin; both
// give no result and leave the block idle and ready. An update item (func 1)
// gives one result on out_o. The entry count register is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while idle, since the
// block itself does not enforce this. An update passes CHECK, then goes
// straight to OUT when the table is unavailable or the clock regressed;
// otherwise ORIGIN (only on the update that latches the origin), ELAPSED,
// ARTIFACT, a PROBE read of the table RAM and a COMPARE pass through the
// shared adder per bisection probe, then TAIL_RD, TAIL and OUT. The next
// item is taken once the result sits in the output register. All times go
// through a single shared TIME_BITS adder, one operation per cycle.
// Reset clears the entry count, the clock origin and the output valid flag;
// the table contents stay undefined until written. If the receiver stalls,
// the result holds in the output register and a finished update waits in
// its last state until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module phase_clock_index_tracker #(
  parameter int TABLE_DEPTH = 256,
  parameter int TIME_BITS   = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pcit_pkg::CFG_W-1:0] cfg_wdata_i,
  pcit_in_if.sink                    in_i,
  pcit_out_if.source                 out_o
);
  import pcit_pkg::*;

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int DW    = $clog2(TABLE_DEPTH + 1);
  localparam int CNT_W = (DW > CFG_W) ? DW : CFG_W;
  localparam int LEN_W = IDX_W + 1;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [CNT_W-1:0]     DEPTH_C = CNT_W'(TABLE_DEPTH);

  state_e state_q, state_d;

  logic [CFG_W-1:0]     cnt_q;
  logic                 latched_q;
  logic [TIME_BITS-1:0] rt_org_q, art_org_q, last_q;

  logic [TIME_BITS-1:0] rt_q, elapsed_q, art_q;
  logic [IDX_W-1:0]     lim_q, maxi_q, mid_q, idx_q;
  logic [LEN_W-1:0]     first_q, len_q, half_q;
  status_e              rstat_q;
  logic                 rerr_q;

  logic                 out_valid_q;
  logic [STAT_W-1:0]    out_status_q;
  logic                 out_rvalid_q;
  logic [IDX_W-1:0]     out_idx_q;
  logic [TIME_BITS-1:0] out_elapsed_q, out_art_q;

  logic                 in_fire, out_free;
  logic                 slot_ok, ram_we, ram_re;
  logic [AW-1:0]        ram_raddr;
  logic [TIME_BITS-1:0] ram_rdata;

  logic [CNT_W-1:0]     count_c, cm1_c;
  logic [IDX_W-1:0]     maxi_c;
  logic                 count_zero;

  logic [TIME_BITS-1:0] opa, opb;
  logic                 cin;
  logic [TIME_BITS:0]   sum;
  logic                 carry, nz;
  logic                 regress;

  // Handshakes
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // Table write on a write item transfer
  assign slot_ok = (32'(in_i.entry_index) < 32'(TABLE_DEPTH));
  assign ram_we  = in_fire && (in_i.func == FUNC_WRITE) && slot_ok;

  // Effective count and clamped search limit
  always_comb begin
    count_c    = (CNT_W'(cnt_q) > DEPTH_C) ? DEPTH_C : CNT_W'(cnt_q);
    count_zero = (count_c == '0);
    cm1_c      = count_c - CNT_W'(1);
    maxi_c     = (CNT_W'(lim_q) > cm1_c) ? cm1_c[IDX_W-1:0] : lim_q;
  end

  // Shared adder: operand select per state
  always_comb begin
    opa = '0;
    opb = '0;
    cin = 1'b0;
    unique case (state_q)
      ST_CHECK: begin
        opa = last_q;
        opb = ~rt_q;
      end
      ST_ELAPSED: begin
        opa = rt_q;
        opb = ~rt_org_q;
        cin = 1'b1;
      end
      ST_ARTIFACT: begin
        opa = art_org_q;
        opb = elapsed_q;
      end
      ST_COMPARE: begin
        opa = ram_rdata;
        opb = ~art_q;
      end
      ST_TAIL: begin
        opa = art_q;
        opb = ~ram_rdata;
      end
      default: begin
        opa = '0;
        opb = '0;
        cin = 1'b0;
      end
    endcase
    sum   = {1'b0, opa} + {1'b0, opb} + {{TIME_BITS{1'b0}}, cin};
    carry = sum[TIME_BITS];
    nz    = |sum[TIME_BITS-1:0];
  end

  // Runtime more than 1 ns before the last one
  assign regress = latched_q && carry && nz;

  // Table read address per state
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state_q)
      ST_CHECK: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      ST_PROBE: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(IDX_W'(first_q + (len_q >> 1)));
      end
      ST_TAIL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(maxi_q);
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  pcit_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(in_i.entry_index)),
    .wdata_i (in_i.entry_time_ns),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.func == FUNC_UPDATE)) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (count_zero) begin
          state_d = ST_OUT;
        end else if (!latched_q) begin
          state_d = ST_ORIGIN;
        end else if (regress) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_ELAPSED;
        end
      end
      ST_ORIGIN:   state_d = ST_ELAPSED;
      ST_ELAPSED:  state_d = ST_ARTIFACT;
      ST_ARTIFACT: state_d = ST_PROBE;
      ST_PROBE: begin
        state_d = (len_q == '0) ? ST_TAIL_RD : ST_COMPARE;
      end
      ST_COMPARE:  state_d = ST_PROBE;
      ST_TAIL_RD:  state_d = ST_TAIL;
      ST_TAIL:     state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // Control state, clock origin and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      latched_q   <= 1'b0;
      rt_org_q    <= '0;
      art_org_q   <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cnt_q <= cfg_wdata_i;
      end
      // Drop the origin on a clear item
      if (in_fire && (in_i.func == FUNC_CLEAR)) begin
        latched_q <= 1'b0;
        rt_org_q  <= '0;
        art_org_q <= '0;
        last_q    <= '0;
      end
      // Advance the last runtime on a good update
      if (state_q == ST_CHECK && !count_zero && latched_q && !regress) begin
        last_q <= rt_q;
      end
      // Latch the origin on the first update
      if (state_q == ST_ORIGIN) begin
        latched_q <= 1'b1;
        rt_org_q  <= rt_q;
        art_org_q <= ram_rdata;
        last_q    <= rt_q;
      end
      // Output register: drop on transfer, load a finished result
      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Update datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rt_q  <= in_i.runtime_ns;
          lim_q <= in_i.index_limit;
        end
      end
      ST_CHECK: begin
        maxi_q <= maxi_c;
        if (count_zero) begin
          rstat_q <= STAT_UNAVAIL;
          rerr_q  <= 1'b1;
        end else begin
          rstat_q <= STAT_REGRESS;
          rerr_q  <= 1'b1;
        end
      end
      ST_ELAPSED: begin
        elapsed_q <= carry ? sum[TIME_BITS-1:0] : '0;
      end
      ST_ARTIFACT: begin
        art_q   <= carry ? TMAX : sum[TIME_BITS-1:0];
        first_q <= '0;
        len_q   <= LEN_W'(maxi_q) + LEN_W'(1);
      end
      ST_PROBE: begin
        half_q <= len_q >> 1;
        mid_q  <= IDX_W'(first_q + (len_q >> 1));
      end
      ST_COMPARE: begin
        // Entry not later than artifact time plus 1 ns: move past it
        if (!(carry && nz)) begin
          first_q <= LEN_W'(mid_q) + LEN_W'(1);
          len_q   <= len_q - half_q - LEN_W'(1);
        end else begin
          len_q   <= half_q;
        end
      end
      ST_TAIL_RD: begin
        if (first_q == '0) begin
          idx_q <= '0;
        end else if ((first_q - LEN_W'(1)) > LEN_W'(maxi_q)) begin
          idx_q <= maxi_q;
        end else begin
          idx_q <= IDX_W'(first_q - LEN_W'(1));
        end
      end
      ST_TAIL: begin
        rstat_q <= (idx_q == maxi_q && carry) ? STAT_TAIL : STAT_OK;
        rerr_q  <= 1'b0;
      end
      default: begin
      end
    endcase

    // Load the output register
    if (state_q == ST_OUT && out_free) begin
      out_status_q  <= rstat_q;
      out_rvalid_q  <= !rerr_q;
      out_idx_q     <= rerr_q ? '0 : idx_q;
      out_elapsed_q <= rerr_q ? '0 : elapsed_q;
      out_art_q     <= rerr_q ? '0 : art_q;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.status           = out_status_q;
  assign out_o.result_valid     = out_rvalid_q;
  assign out_o.phase_index      = out_idx_q;
  assign out_o.elapsed_ns       = out_elapsed_q;
  assign out_o.artifact_time_ns = out_art_q;

endmodule

`default_nettype wire
